// ===== src/meter_teleinfo_word_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// meter_teleinfo_word_parser_top_assert.svh
// Assertion macros used by the teleinfo word parser checker.
// Each macro expects clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef METER_TELEINFO_WORD_PARSER_TOP_ASSERT_SVH
`define METER_TELEINFO_WORD_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define MTWP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtwp assertion failed");

// next-cycle implication
`define MTWP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtwp assertion failed");

`endif

// ===== src/mtwp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwp_pkg
// Types and constants of the teleinfo word parser.
// ----------------------------------------------------------------------------
package mtwp_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [1:0]  status_t;
  typedef logic [3:0]  field_t;
  typedef logic [47:0] value_t;

  localparam status_t ST_CORRUPT  = 2'd0;
  localparam status_t ST_OK       = 2'd1;
  localparam status_t ST_COMPLETE = 2'd2;

  localparam field_t F_NONE     = 4'd0;
  localparam field_t F_ADCO     = 4'd1;
  localparam field_t F_OPTARIF  = 4'd2;
  localparam field_t F_ISOUSC   = 4'd3;
  localparam field_t F_BASE     = 4'd4;
  localparam field_t F_PTEC     = 4'd5;
  localparam field_t F_IINST    = 4'd6;
  localparam field_t F_IMAX     = 4'd7;
  localparam field_t F_PAPP     = 4'd8;
  localparam field_t F_MOTDETAT = 4'd9;
  localparam field_t F_ADPS     = 4'd10;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_STX   = 8'h02;
  localparam char_t CH_ETX   = 8'h03;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CHK_BIAS = 8'h20;
  localparam logic [5:0] CHK_MASK = 6'b111111;

  localparam value_t VAL_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [3:0] LABEL_MAX = 4'd8;
  localparam logic [3:0] LABEL_SAT = 4'd9;

  // labels, right aligned
  localparam logic [63:0] LBL_ADCO     = 64'h0000_0000_4144_434F;
  localparam logic [63:0] LBL_OPTARIF  = 64'h004F_5054_4152_4946;
  localparam logic [63:0] LBL_ISOUSC   = 64'h0000_4953_4F55_5343;
  localparam logic [63:0] LBL_BASE     = 64'h0000_0000_4241_5345;
  localparam logic [63:0] LBL_PTEC     = 64'h0000_0000_5054_4543;
  localparam logic [63:0] LBL_IINST    = 64'h0000_0049_494E_5354;
  localparam logic [63:0] LBL_IMAX     = 64'h0000_0000_494D_4158;
  localparam logic [63:0] LBL_PAPP     = 64'h0000_0000_5041_5050;
  localparam logic [63:0] LBL_MOTDETAT = 64'h4D4F_5444_4554_4154;
  localparam logic [63:0] LBL_ADPS     = 64'h0000_0000_4144_5053;

  // tariff option words
  localparam logic [31:0] OPT_BASE = 32'h4241_5345;
  localparam logic [31:0] OPT_HC   = 32'h4843_2E2E;
  localparam logic [31:0] OPT_EJP  = 32'h454A_502E;
  localparam logic [23:0] OPT_BBR  = 24'h42_4252;

  // tariff period words, code is index plus one
  localparam int PTEC_NUM = 11;
  localparam logic [31:0] PTEC_NAMES [PTEC_NUM] = '{
    32'h5448_2E2E, 32'h4843_2E2E, 32'h4850_2E2E, 32'h484E_2E2E,
    32'h504D_2E2E, 32'h4843_4A42, 32'h4850_4A42, 32'h4843_4A57,
    32'h4850_4A57, 32'h4843_4A52, 32'h4850_4A52
  };

  typedef struct packed {
    logic        active;
    logic        text_ended;
    char_t       lead;
    logic [7:0]  sum;
    char_t       rc0;
    char_t       rc1;
    logic [63:0] label_text;
    logic        label_closed;
    logic [3:0]  label_len;
    value_t      data_text;
    value_t      digit_value;
    logic        digits_running;
  } word_t;

  typedef struct packed {
    status_t status;
    field_t  field_code;
    value_t  field_value;
    logic    alarm;
  } res_t;

endpackage

// ===== src/mtwp_in_if.sv =====
// ----------------------------------------------------------------------------
// mtwp_in_if
// Character channel: one character a beat, last one of a word marked.
// ----------------------------------------------------------------------------
interface mtwp_in_if;
  logic                valid;
  logic                ready;
  mtwp_pkg::char_t     char_code;
  logic                word_end;

  modport source (output valid, output char_code, output word_end, input ready);
  modport sink   (input valid, input char_code, input word_end, output ready);
endinterface

// ===== src/mtwp_out_if.sv =====
// ----------------------------------------------------------------------------
// mtwp_out_if
// Result channel: one beat per word.
// ----------------------------------------------------------------------------
interface mtwp_out_if;
  logic              valid;
  logic              ready;
  mtwp_pkg::status_t status;
  mtwp_pkg::field_t  field_code;
  mtwp_pkg::value_t  field_value;
  logic              alarm;

  modport source (output valid, output status, output field_code, output field_value,
                  output alarm, input ready);
  modport sink   (input valid, input status, input field_code, input field_value,
                  input alarm, output ready);
endinterface

// ===== src/mtwp_word_acc.sv =====
// ----------------------------------------------------------------------------
// mtwp_word_acc
// Per-word accumulator: position, checksum, label, data text and digits.
// ----------------------------------------------------------------------------
module mtwp_word_acc #(
  parameter int WORD_LEN_LIMIT = 63,
  parameter int PW             = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  mtwp_pkg::char_t   c,
  input  logic              word_end,
  output mtwp_pkg::word_t   post,
  output logic [PW-1:0]     post_pos
);
  import mtwp_pkg::*;

  localparam logic [PW-1:0] LIM   = PW'(WORD_LEN_LIMIT);
  localparam logic [PW-1:0] LIM_P = PW'(WORD_LEN_LIMIT + 1);

  word_t         w_r, w_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          skip;
  logic [PW-1:0] d;
  logic [3:0]    nl;
  logic [51:0]   prod;

  always_comb begin
    post     = w_r;
    post_pos = pos_r;
    post.active = 1'b1;
    skip = !w_r.active && (c == CH_LF);
    d    = pos_r - PW'(w_r.label_len) - PW'(1);
    nl   = (w_r.label_len < LABEL_SAT) ? w_r.label_len + 4'd1 : w_r.label_len;
    prod = ({4'b0, w_r.digit_value} << 3) + ({4'b0, w_r.digit_value} << 1)
           + 52'(c[3:0]);
    if (!skip && !w_r.text_ended) begin
      if (c == CH_NUL) begin
        post.text_ended = 1'b1;
      end else if (pos_r >= LIM) begin
        post_pos = LIM_P;
      end else begin
        if (pos_r == '0) post.lead = c;
        if (pos_r >= PW'(2)) post.sum = w_r.sum + w_r.rc1;
        post.rc1 = w_r.rc0;
        post.rc0 = c;
        post_pos = pos_r + PW'(1);
        if (!w_r.label_closed) begin
          if (c == CH_SPACE) begin
            post.label_closed   = 1'b1;
            post.digits_running = 1'b1;
            post.digit_value    = '0;
          end else begin
            post.label_len = nl;
            if (nl <= LABEL_MAX) post.label_text = {w_r.label_text[55:0], c};
          end
        end else begin
          for (int k = 0; k < 6; k++) begin
            if (d == PW'(k)) begin
              post.data_text[47-8*k -: 8] = w_r.data_text[47-8*k -: 8] | c;
            end
          end
          if (w_r.digits_running) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              post.digit_value = (prod[51:48] != 4'd0) ? VAL_MAX : prod[47:0];
            end else begin
              post.digits_running = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    w_nxt   = w_r;
    pos_nxt = pos_r;
    if (adv) begin
      w_nxt   = word_end ? '0 : post;
      pos_nxt = word_end ? '0 : post_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= '0;
      pos_r <= '0;
    end else begin
      w_r   <= w_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== src/mtwp_word_decode.sv =====
// ----------------------------------------------------------------------------
// mtwp_word_decode
// Word-end decision: frame markers, checksum, label match, value select.
// Holds the frame and alarm flags.
// ----------------------------------------------------------------------------
module mtwp_word_decode #(
  parameter int WORD_LEN_LIMIT = 63,
  parameter int PW             = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_end,
  input  mtwp_pkg::word_t  w,
  input  logic [PW-1:0]    pos,
  output mtwp_pkg::res_t   res
);
  import mtwp_pkg::*;

  logic   frame_open_r, frame_open_nxt;
  logic   alarm_seen_r, alarm_seen_nxt;
  logic   alarm_level_r, alarm_level_nxt;
  char_t  chk;
  logic   ok;
  value_t opt_code, ptec_code;
  logic [31:0] w4;

  function automatic logic lbl_is(input logic [63:0] txt, input logic [3:0] len,
                                  input logic [63:0] ref_txt, input logic [3:0] n);
    return (len == n) && (txt == ref_txt);
  endfunction

  always_comb begin
    w4 = w.data_text[47:16];
    if (w4 == OPT_BASE)                   opt_code = 48'd1;
    else if (w4 == OPT_HC)                opt_code = 48'd2;
    else if (w4 == OPT_EJP)               opt_code = 48'd3;
    else if (w.data_text[47:24] == OPT_BBR) opt_code = 48'd4;
    else                                  opt_code = '0;
    ptec_code = '0;
    for (int i = PTEC_NUM - 1; i >= 0; i--) begin
      if (w4 == PTEC_NAMES[i]) ptec_code = 48'(i + 1);
    end
  end

  always_comb begin
    chk = {2'b00, w.sum[5:0] & CHK_MASK} + CHK_BIAS;
    ok  = (pos <= PW'(WORD_LEN_LIMIT)) && (chk == w.rc0);
    frame_open_nxt  = frame_open_r;
    alarm_seen_nxt  = alarm_seen_r;
    alarm_level_nxt = alarm_level_r;
    res.status      = ST_OK;
    res.field_code  = F_NONE;
    res.field_value = '0;
    if (pos == '0 || w.lead == CH_CR) begin
      res.status = ST_OK;
    end else if (w.lead == CH_STX) begin
      alarm_seen_nxt = 1'b0;
      frame_open_nxt = 1'b1;
    end else if (w.lead == CH_ETX) begin
      if (frame_open_r) begin
        if (!alarm_seen_r) begin
          alarm_level_nxt = 1'b0;
          res.field_code  = F_ADPS;
        end
        frame_open_nxt = 1'b0;
        res.status     = ST_COMPLETE;
      end
    end else if (!ok) begin
      frame_open_nxt = 1'b0;
      res.status     = ST_CORRUPT;
    end else if (w.label_closed) begin
      if (lbl_is(w.label_text, w.label_len, LBL_ADCO, 4'd4)) begin
        res.field_code = F_ADCO;     res.field_value = w.digit_value;
      end else if (lbl_is(w.label_text, w.label_len, LBL_OPTARIF, 4'd7)) begin
        res.field_code = F_OPTARIF;  res.field_value = opt_code;
      end else if (lbl_is(w.label_text, w.label_len, LBL_ISOUSC, 4'd6)) begin
        res.field_code = F_ISOUSC;   res.field_value = w.digit_value;
      end else if (lbl_is(w.label_text, w.label_len, LBL_BASE, 4'd4)) begin
        res.field_code = F_BASE;     res.field_value = w.digit_value;
      end else if (lbl_is(w.label_text, w.label_len, LBL_PTEC, 4'd4)) begin
        res.field_code = F_PTEC;     res.field_value = ptec_code;
      end else if (lbl_is(w.label_text, w.label_len, LBL_IINST, 4'd5)) begin
        res.field_code = F_IINST;    res.field_value = w.digit_value;
      end else if (lbl_is(w.label_text, w.label_len, LBL_IMAX, 4'd4)) begin
        res.field_code = F_IMAX;     res.field_value = w.digit_value;
      end else if (lbl_is(w.label_text, w.label_len, LBL_PAPP, 4'd4)) begin
        res.field_code = F_PAPP;     res.field_value = w.digit_value;
      end else if (lbl_is(w.label_text, w.label_len, LBL_MOTDETAT, 4'd8)) begin
        res.field_code = F_MOTDETAT; res.field_value = w.data_text;
      end else if (lbl_is(w.label_text, w.label_len, LBL_ADPS, 4'd4)) begin
        res.field_code  = F_ADPS;    res.field_value = w.digit_value;
        alarm_level_nxt = 1'b1;
        alarm_seen_nxt  = 1'b1;
      end
    end
    res.alarm = alarm_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      alarm_seen_r  <= 1'b0;
      alarm_level_r <= 1'b0;
    end else if (adv_end) begin
      frame_open_r  <= frame_open_nxt;
      alarm_seen_r  <= alarm_seen_nxt;
      alarm_level_r <= alarm_level_nxt;
    end
  end

endmodule

// ===== src/meter_teleinfo_word_parser_top.sv =====
// ----------------------------------------------------------------------------
// meter_teleinfo_word_parser_top
// Teleinfo (historic mode) word parser: characters in, one result per word.
//
//   channel  dir  payload                                    beat
//   in_ch    in   char_code[7:0], word_end                   one character
//   out_ch   out  status[1:0], field_code[3:0],              one word result
//                 field_value[47:0], alarm
//
// One character a cycle unless a word end waits on a stalled result. An
// accepted character sits in the input register; the accumulator and word-end
// decode work on it there and its word's result lands in the output register.
// Synchronous active-low reset clears all word and frame state.
// A stalled result only holds characters that end a word; others pass.
// ----------------------------------------------------------------------------
module meter_teleinfo_word_parser_top #(
  parameter int WORD_LEN_LIMIT = 63
) (
  input logic       clk,
  input logic       rst_n,
  mtwp_in_if.sink   in_ch,
  mtwp_out_if.source out_ch
);
  import mtwp_pkg::*;

  localparam int PW = $clog2(WORD_LEN_LIMIT + 2);

  logic          in_v_r;
  char_t         in_c_r;
  logic          in_end_r;
  logic          adv;
  logic          out_v_r, out_v_nxt;
  res_t          out_r;
  res_t          res;
  word_t         post;
  logic [PW-1:0] post_pos;

  assign adv         = in_v_r && (!in_end_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_c_r   <= in_ch.char_code;
      in_end_r <= in_ch.word_end;
    end
  end

  mtwp_word_acc #(
    .WORD_LEN_LIMIT (WORD_LEN_LIMIT),
    .PW             (PW)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .c        (in_c_r),
    .word_end (in_end_r),
    .post     (post),
    .post_pos (post_pos)
  );

  mtwp_word_decode #(
    .WORD_LEN_LIMIT (WORD_LEN_LIMIT),
    .PW             (PW)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv_end (adv && in_end_r),
    .w       (post),
    .pos     (post_pos),
    .res     (res)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv && in_end_r) out_v_nxt = 1'b1;
    else if (out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_end_r) out_r <= res;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.field_code  = out_r.field_code;
  assign out_ch.field_value = out_r.field_value;
  assign out_ch.alarm       = out_r.alarm;

endmodule

// ===== src/mtwp_checker.sv =====
// ----------------------------------------------------------------------------
// mtwp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "meter_teleinfo_word_parser_top_assert.svh"

module mtwp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input mtwp_pkg::status_t out_status,
  input mtwp_pkg::field_t  out_field_code,
  input mtwp_pkg::value_t  out_field_value,
  input logic              out_alarm
);
  import mtwp_pkg::*;

  `MTWP_ASSERT_IMP(a_none_no_value, out_valid && out_field_code == F_NONE, out_field_value == '0)
  `MTWP_ASSERT_IMP(a_corrupt_no_field, out_valid && out_status == ST_CORRUPT, out_field_code == F_NONE)
  `MTWP_ASSERT_IMP(a_close_clears_alarm, out_valid && out_status == ST_COMPLETE && out_field_code == F_ADPS, !out_alarm && out_field_value == '0)
  `MTWP_ASSERT_IMP(a_adps_sets_alarm, out_valid && out_status == ST_OK && out_field_code == F_ADPS, out_alarm)
  `MTWP_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_field_value))

endmodule

bind meter_teleinfo_word_parser_top mtwp_checker u_mtwp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_field_code  (out_ch.field_code),
  .out_field_value (out_ch.field_value),
  .out_alarm       (out_ch.alarm)
);
